// ===== design/ins_sort_pkg.sv =====
// ----------------------------------------------------------------------------
// ins_sort_pkg
// shared types for the insertion sorter cell chain
// ----------------------------------------------------------------------------
package ins_sort_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] value_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   shl;
    value_t value;
  } cell_cmd_t;

endpackage

// ===== design/ins_sort_cell.sv =====
// ----------------------------------------------------------------------------
// ins_sort_cell
// one storage cell of the sort chain: inserts, shifts up on insert, shifts
// down toward the output on drain
// ----------------------------------------------------------------------------
module ins_sort_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                  clk,
  input  ins_sort_pkg::cell_cmd_t cmd,
  input  logic [CNT_W-1:0]      count,
  input  ins_sort_pkg::value_t  left_value,
  input  logic                  left_gt,
  input  logic                  left_occ,
  input  ins_sort_pkg::value_t  right_value,
  output ins_sort_pkg::value_t  value,
  output logic                  gt,
  output logic                  occ
);
  import ins_sort_pkg::*;

  logic first_empty;

  assign occ         = count > CNT_W'(INDEX);
  assign gt          = occ && (value > cmd.value);
  assign first_empty = !occ && left_occ;

  always_ff @(posedge clk) begin
    if (cmd.shl) begin
      value <= right_value;
    end else if (cmd.ins) begin
      if (left_gt) begin
        value <= left_value;
      end else if (gt || first_empty) begin
        value <= cmd.value;
      end
    end
  end

endmodule

// ===== design/insertion_sorter.sv =====
// loading: an accepted beat is stored unless the chain is full; the first sorted beat is offered
//   the cycle after the beat that ends the set
// throughput: one input beat per cycle while loading, one output beat per
//   cycle while draining and m_tready is high; input waits until all stored beats drain
// reset: rst (synchronous) empties the chain and clears the overflow flag
// ----------------------------------------------------------------------------
// insertion_sorter
// cell chain insertion sort of signed values, emitted in ascending order
// ----------------------------------------------------------------------------
module insertion_sorter #(
  parameter int STORE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ins_sort_pkg::value_t s_tdata,   // [31:0] sample_value
  input  logic                 s_tlast,   // set_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output ins_sort_pkg::value_t m_tdata,   // [31:0] sorted_value
  output logic                 m_tlast,   // run_end
  output logic                 m_tuser    // [0] overflowed
);
  import ins_sort_pkg::*;

  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef enum logic {LOAD, DRAIN} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             drop;
  logic             in_beat;
  logic             out_beat;
  logic             full;
  cell_cmd_t        cmd;

  value_t cell_value [STORE_DEPTH];
  logic   cell_gt    [STORE_DEPTH];
  logic   cell_occ   [STORE_DEPTH];

  assign s_tready = (state == LOAD);
  assign in_beat  = s_tvalid && s_tready;
  assign m_tvalid = (state == DRAIN);
  assign out_beat = m_tvalid && m_tready;
  assign full     = (count == CNT_W'(STORE_DEPTH));

  assign cmd.ins   = in_beat && !full;
  assign cmd.shl   = out_beat;
  assign cmd.value = s_tdata;

  assign m_tdata = cell_value[0];
  assign m_tlast = (count == CNT_W'(1));
  assign m_tuser = drop;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    value_t lv;
    logic   lg;
    logic   lo;
    value_t rv;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lv = cell_value[i-1];
      assign lg = cell_gt[i-1];
      assign lo = cell_occ[i-1];
    end
    if (i == STORE_DEPTH - 1) begin : g_last
      assign rv = '0;
    end else begin : g_inner
      assign rv = cell_value[i+1];
    end
    ins_sort_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .left_value  (lv),
      .left_gt     (lg),
      .left_occ    (lo),
      .right_value (rv),
      .value       (cell_value[i]),
      .gt          (cell_gt[i]),
      .occ         (cell_occ[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
      drop  <= 1'b0;
    end else begin
      case (state)
        LOAD: begin
          if (in_beat) begin
            if (full) begin
              drop <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (s_tlast) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          if (out_beat) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state <= LOAD;
              drop  <= 1'b0;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule
